// ===== design/bhpq_pkg.sv =====
package bhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int LEVELS   = $clog2(CAPACITY + 1);
  localparam int NCELL    = LEVELS - 1;
  localparam int CNT_W    = LEVELS;
  localparam int N_W      = CNT_W + 1;
  localparam int OFF_W    = LEVELS - 1;
  localparam int ROW_W    = (OFF_W > 1) ? OFF_W - 1 : 1;
  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SIFT,
    S_FIN
  } state_t;

  typedef struct packed {
    func_t                     func;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  top_value;
    logic                      top_valid;
    logic [CNT_W-1:0]          entry_count;
    status_t                   status;
  } rsp_t;

  // token moving along the chain of level cells
  typedef struct packed {
    logic                      active;
    logic [OFF_W-1:0]          off;
    logic signed [DATA_W-1:0]  val;
  } tok_t;

  // single entry write into a neighbouring level
  typedef struct packed {
    logic                      active;
    logic [OFF_W-1:0]          off;
    logic signed [DATA_W-1:0]  val;
  } wr_t;

  typedef struct packed {
    logic                      active;
    logic [OFF_W-1:0]          off;
  } fetch_t;

  function automatic logic precedes(input logic order,
                                    input logic signed [DATA_W-1:0] a,
                                    input logic signed [DATA_W-1:0] b);
    return order ? (a > b) : (a < b);
  endfunction

  function automatic int level_rows(input int l);
    int full;
    int ent;
    full = 1 << l;
    ent  = CAPACITY - (full - 1);
    if (ent > full) ent = full;
    return (ent + 1) >> 1;
  endfunction

  // level of a 1-based heap index: position of its top set bit
  function automatic logic [LVL_W-1:0] level_of(input logic [CNT_W-1:0] n);
    logic [LVL_W-1:0] lv;
    lv = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (n[i]) lv = LVL_W'(i);
    end
    return lv;
  endfunction

  function automatic logic [OFF_W-1:0] offset_of(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] m;
    m = n;
    m[level_of(n)] = 1'b0;
    return m[OFF_W-1:0];
  endfunction

endpackage

// ===== design/bhpq_ram.sv =====
module bhpq_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 32
) (
  input  logic                               clk,
  input  logic [1:0]                         we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [1:0][WIDTH-1:0]              wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [1:0][WIDTH-1:0]              rdata
);

  logic [1:0][WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we[0]) mem[waddr][0] <= wdata[0];
    if (we[1]) mem[waddr][1] <= wdata[1];
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bhpq_cell.sv =====
module bhpq_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [bhpq_pkg::LVL_W-1:0]         lvl,
  input  logic                               order_mode,
  input  logic [bhpq_pkg::CNT_W-1:0]         cnt,
  input  bhpq_pkg::tok_t                     dn_in,
  input  bhpq_pkg::tok_t                     up_in,
  output bhpq_pkg::tok_t                     dn_out,
  output bhpq_pkg::tok_t                     up_out,
  input  bhpq_pkg::wr_t                      wr_from_above,
  input  bhpq_pkg::wr_t                      wr_from_below,
  output bhpq_pkg::wr_t                      wr_to_above,
  output bhpq_pkg::wr_t                      wr_to_below,
  input  bhpq_pkg::fetch_t                   fetch,
  output logic                               fetch_valid,
  output logic signed [bhpq_pkg::DATA_W-1:0] fetch_data,
  output logic                               done,
  output logic [bhpq_pkg::ROW_W-1:0]         ram_rrow,
  output logic [bhpq_pkg::ROW_W-1:0]         ram_wrow,
  output logic [1:0]                         ram_we,
  output logic [1:0][bhpq_pkg::DATA_W-1:0]   ram_wdata,
  input  logic [1:0][bhpq_pkg::DATA_W-1:0]   ram_rdata
);
  import bhpq_pkg::*;

  logic                     act;
  logic                     fet;
  logic                     dir_dn;
  logic                     sel;
  logic [OFF_W-1:0]         t_off;
  logic signed [DATA_W-1:0] t_val;

  logic                     rd_sel;
  logic [OFF_W-1:0]         anc_off;
  logic signed [DATA_W-1:0] anc;
  logic signed [DATA_W-1:0] lft;
  logic signed [DATA_W-1:0] rgt;
  logic signed [DATA_W-1:0] best;
  logic                     bsel;
  logic                     moved;
  logic                     climb;
  logic [N_W-1:0]           n_l;
  logic [N_W-1:0]           n_r;
  logic                     lv;
  logic                     rv;
  wr_t                      wr;

  // read side: children pair on the way down, ancestor on the way up, fetched entry on a pop
  always_comb begin
    anc_off  = up_in.off >> 1;
    rd_sel   = 1'b0;
    ram_rrow = ROW_W'(dn_in.off);
    if (up_in.active) begin
      rd_sel   = anc_off[0];
      ram_rrow = ROW_W'(anc_off >> 1);
    end else if (fetch.active) begin
      rd_sel   = fetch.off[0];
      ram_rrow = ROW_W'(fetch.off >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      fet <= 1'b0;
    end else begin
      act <= dn_in.active | up_in.active;
      fet <= fetch.active;
    end
    dir_dn <= dn_in.active;
    sel    <= rd_sel;
    t_off  <= dn_in.active ? dn_in.off : up_in.off;
    t_val  <= dn_in.active ? dn_in.val : up_in.val;
  end

  always_comb begin
    anc   = sel ? $signed(ram_rdata[1]) : $signed(ram_rdata[0]);
    lft   = $signed(ram_rdata[0]);
    rgt   = $signed(ram_rdata[1]);
    n_l   = (N_W'(1) << lvl) | N_W'({t_off, 1'b0});
    n_r   = n_l | N_W'(1);
    lv    = n_l <= N_W'(cnt);
    rv    = n_r <= N_W'(cnt);
    climb = precedes(order_mode, t_val, anc);
    best  = t_val;
    bsel  = 1'b0;
    moved = 1'b0;
    if (lv && precedes(order_mode, lft, best)) begin
      best  = lft;
      moved = 1'b1;
    end
    if (rv && precedes(order_mode, rgt, best)) begin
      best  = rgt;
      bsel  = 1'b1;
      moved = 1'b1;
    end

    dn_out      = '0;
    up_out      = '0;
    wr_to_above = '0;
    wr_to_below = '0;
    done        = 1'b0;
    if (act && !dir_dn) begin
      wr_to_below = '{active: 1'b1, off: t_off, val: climb ? anc : t_val};
      if (climb) begin
        up_out = '{active: 1'b1, off: t_off >> 1, val: t_val};
      end else begin
        done = 1'b1;
      end
    end else if (act && dir_dn) begin
      wr_to_above = '{active: 1'b1, off: t_off, val: best};
      if (moved) begin
        dn_out = '{active: 1'b1, off: (t_off << 1) | OFF_W'(bsel), val: t_val};
      end else begin
        done = 1'b1;
      end
    end
  end

  assign fetch_valid = fet;
  assign fetch_data  = anc;

  // writes arrive from one neighbour at a time
  assign wr        = wr_from_above.active ? wr_from_above : wr_from_below;
  assign ram_we    = {wr.active & wr.off[0], wr.active & ~wr.off[0]};
  assign ram_wrow  = ROW_W'(wr.off >> 1);
  assign ram_wdata = {wr.val, wr.val};

endmodule

// ===== design/binary_heap_priority_queue.sv =====
// Priority queue of up to 64 signed 32-bit entries kept as a binary heap, one
// cell per heap level below the root, each cell owning that level's storage.
// A push climbs from the new leaf and a pop sinks the moved last entry from
// the root, one level per clock as a token passes from cell to cell. A push
// gives its result once the climb ends at a cell or the root; a pop first
// fetches the last entry from its level and then sinks it from the root until
// it settles. Overflow, underflow, a push into an empty heap and a pop of the
// last entry need no sift and go straight to the finish state, which loads the
// output register once it is free. One item is worked on at a time; a result
// may wait in the output register while the next item is taken, and the one
// after waits until it has gone.
// order_mode 0 keeps the smallest entry on top, 1 the largest; changing it
// while entries are held does not reorder them. Every item gives one result.
module binary_heap_priority_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_data,
  input  logic             req_valid,
  output logic             req_stall,
  input  bhpq_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output bhpq_pkg::rsp_t   rsp
);
  import bhpq_pkg::*;

  state_t                   state;
  state_t                   state_next;
  logic                     order_mode;
  logic [CNT_W-1:0]         fill;
  logic [CNT_W-1:0]         fill_next;
  status_t                  status;
  status_t                  status_next;
  logic signed [DATA_W-1:0] root;
  tok_t                     inj;
  tok_t                     inj_next;
  logic [LVL_W-1:0]         inj_lvl;
  logic [LVL_W-1:0]         inj_lvl_next;
  fetch_t                   fetch_req;
  fetch_t                   fetch_next;
  logic [LVL_W-1:0]         fetch_lvl;
  logic [LVL_W-1:0]         fetch_lvl_next;
  tok_t                     root_dn;
  tok_t                     root_dn_next;
  tok_t                     root_up;
  tok_t                     root_up_next;
  wr_t                      root_wr;
  wr_t                      end_wr;
  logic                     root_climb;
  logic                     root_done;
  logic                     root_load;
  logic                     rsp_load;
  logic                     accept;
  logic                     done_any;
  logic                     fv_any;
  logic signed [DATA_W-1:0] fd;
  logic [CNT_W-1:0]         n_push;

  tok_t                     c_dn_in  [1:NCELL];
  tok_t                     c_up_in  [1:NCELL];
  tok_t                     c_dn_out [1:NCELL];
  tok_t                     c_up_out [1:NCELL];
  wr_t                      c_wa_in  [1:NCELL];
  wr_t                      c_wb_in  [1:NCELL];
  wr_t                      c_wa_out [1:NCELL];
  wr_t                      c_wb_out [1:NCELL];
  fetch_t                   c_fetch  [1:NCELL];
  logic signed [DATA_W-1:0] c_fd     [1:NCELL];
  logic [NCELL:1]           c_fv;
  logic [NCELL:1]           c_done;

  for (genvar l = 1; l <= NCELL; l++) begin : g_lvl
    localparam int ROWS = level_rows(l);
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [ROW_W-1:0]         rrow;
    logic [ROW_W-1:0]         wrow;
    logic [1:0]               we;
    logic [1:0][DATA_W-1:0]   wdata;
    logic [1:0][DATA_W-1:0]   rdata;

    if (l == 1) begin : g_top
      assign c_dn_in[l] = root_dn;
      assign c_wa_in[l] = root_wr;
    end else begin : g_mid
      assign c_dn_in[l] = c_dn_out[l-1];
      assign c_wa_in[l] = c_wb_out[l-1];
    end

    if (l == NCELL) begin : g_last
      assign c_up_in[l] = (inj.active && inj_lvl == LVL_W'(l)) ? inj : '0;
      assign c_wb_in[l] = end_wr;
    end else begin : g_inner
      assign c_up_in[l] = (inj.active && inj_lvl == LVL_W'(l)) ? inj : c_up_out[l+1];
      assign c_wb_in[l] = c_wa_out[l+1];
    end

    assign c_fetch[l] = '{active: fetch_req.active && fetch_lvl == LVL_W'(l),
                          off: fetch_req.off};

    bhpq_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .lvl           (LVL_W'(l)),
      .order_mode    (order_mode),
      .cnt           (fill),
      .dn_in         (c_dn_in[l]),
      .up_in         (c_up_in[l]),
      .dn_out        (c_dn_out[l]),
      .up_out        (c_up_out[l]),
      .wr_from_above (c_wa_in[l]),
      .wr_from_below (c_wb_in[l]),
      .wr_to_above   (c_wa_out[l]),
      .wr_to_below   (c_wb_out[l]),
      .fetch         (c_fetch[l]),
      .fetch_valid   (c_fv[l]),
      .fetch_data    (c_fd[l]),
      .done          (c_done[l]),
      .ram_rrow      (rrow),
      .ram_wrow      (wrow),
      .ram_we        (we),
      .ram_wdata     (wdata),
      .ram_rdata     (rdata)
    );

    bhpq_ram #(
      .DEPTH (ROWS),
      .WIDTH (DATA_W)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (wrow[AW-1:0]),
      .wdata (wdata),
      .raddr (rrow[AW-1:0]),
      .rdata (rdata)
    );
  end

  // a token leaving the deepest cell settles in that level
  assign end_wr = '{active: c_dn_out[NCELL].active, off: c_dn_out[NCELL].off,
                    val: c_dn_out[NCELL].val};

  // root step of a climb
  always_comb begin
    root_up_next = (inj.active && inj_lvl == '0) ? inj : c_up_out[1];
    root_climb   = precedes(order_mode, root_up.val, root);
    root_wr      = '0;
    root_done    = 1'b0;
    if (root_up.active) begin
      root_wr   = '{active: 1'b1, off: root_up.off, val: root_climb ? root : root_up.val};
      root_done = 1'b1;
    end
  end

  always_comb begin
    fd = '0;
    for (int l = 1; l <= NCELL; l++) begin
      if (c_fv[l]) fd = fd | c_fd[l];
    end
  end

  assign fv_any    = |c_fv;
  assign done_any  = (|c_done) | root_done | end_wr.active;
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign n_push    = fill + CNT_W'(1);

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    status_next    = status;
    inj_next       = '0;
    inj_lvl_next   = inj_lvl;
    fetch_next     = '0;
    fetch_lvl_next = fetch_lvl;
    root_dn_next   = '0;
    root_load      = 1'b0;
    rsp_load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          status_next = STAT_OK;
          unique case (req.func)
            FUNC_PUSH: begin
              if (fill == CNT_W'(CAPACITY)) begin
                status_next = STAT_OVERFLOW;
                state_next  = S_FIN;
              end else begin
                fill_next = n_push;
                if (fill == '0) begin
                  root_load  = 1'b1;
                  state_next = S_FIN;
                end else begin
                  inj_next     = '{active: 1'b1, off: offset_of(n_push), val: req.value};
                  inj_lvl_next = level_of(n_push) - LVL_W'(1);
                  state_next   = S_SIFT;
                end
              end
            end
            FUNC_POP: begin
              if (fill == '0) begin
                status_next = STAT_UNDERFLOW;
                state_next  = S_FIN;
              end else begin
                fill_next = fill - CNT_W'(1);
                if (fill == CNT_W'(1)) begin
                  state_next = S_FIN;
                end else begin
                  fetch_next     = '{active: 1'b1, off: offset_of(fill)};
                  fetch_lvl_next = level_of(fill);
                  state_next     = S_FETCH;
                end
              end
            end
          endcase
        end
      end
      S_FETCH: begin
        if (fv_any) begin
          root_dn_next = '{active: 1'b1, off: '0, val: fd};
          state_next   = S_SIFT;
        end
      end
      S_SIFT: begin
        if (done_any) state_next = S_FIN;
      end
      S_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      order_mode <= 1'b0;
      fill       <= '0;
      inj        <= '0;
      fetch_req  <= '0;
      root_dn    <= '0;
      root_up    <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      inj       <= inj_next;
      fetch_req <= fetch_next;
      root_dn   <= root_dn_next;
      root_up   <= root_up_next;
      if (cfg_we) order_mode <= cfg_data;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    status    <= status_next;
    inj_lvl   <= inj_lvl_next;
    fetch_lvl <= fetch_lvl_next;
    if (root_load) begin
      root <= req.value;
    end else if (root_up.active && root_climb) begin
      root <= root_up.val;
    end else if (c_wa_out[1].active) begin
      root <= c_wa_out[1].val;
    end
    if (rsp_load) begin
      rsp.top_value   <= (fill != '0) ? root : '0;
      rsp.top_valid   <= (fill != '0);
      rsp.entry_count <= fill;
      rsp.status      <= status;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_one_finish: assert property (@(posedge clk) disable iff (rst)
    $onehot0({c_done, root_done, end_wr.active}))
    else $error("more than one level finished a sift");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !(inj.active || fetch_req.active || root_dn.active || root_up.active))
    else $error("token in flight while idle");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    accept && req.func == FUNC_PUSH && fill != CNT_W'(CAPACITY)
    |=> fill == $past(fill) + CNT_W'(1))
    else $error("push did not grow the heap");

  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> rsp.entry_count == fill)
    else $error("result count differs from held entries");
`endif

endmodule

// ===== tb/bhpq_checker.sv =====
`timescale 1ns / 1ps
module bhpq_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_data,
  input  logic           req_valid,
  input  logic           req_stall,
  input  bhpq_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  bhpq_pkg::rsp_t rsp,
  output int             errors,
  output int             outstanding
);
  import bhpq_pkg::*;

  localparam int SHOWN_MAX = 60;

  logic signed [DATA_W-1:0] model_heap [CAPACITY];
  int   model_fill = 0;
  logic model_max_first = 1'b0;
  rsp_t results_due [$];
  int   items_taken = 0;
  int   results_seen = 0;
  int   mismatches = 0;

  assign errors      = mismatches;
  assign outstanding = items_taken - results_seen;

  function automatic logic ranks_higher(input logic signed [DATA_W-1:0] a,
                                        input logic signed [DATA_W-1:0] b);
    return model_max_first ? (a > b) : (a < b);
  endfunction

  function automatic void swap_entries(input int i, input int j);
    logic signed [DATA_W-1:0] tmp;
    tmp = model_heap[i];
    model_heap[i] = model_heap[j];
    model_heap[j] = tmp;
  endfunction

  function automatic rsp_t apply_heap_op(input req_t r);
    rsp_t res;
    int   pos;
    int   best;
    int   kid;
    logic moved;
    res = '0;
    res.status = STAT_OK;
    if (r.func == FUNC_PUSH) begin
      if (model_fill >= CAPACITY) begin
        res.status = STAT_OVERFLOW;
      end else begin
        pos = model_fill;
        model_heap[pos] = r.value;
        model_fill++;
        while (pos > 0 && ranks_higher(model_heap[pos], model_heap[(pos - 1) / 2])) begin
          swap_entries(pos, (pos - 1) / 2);
          pos = (pos - 1) / 2;
        end
      end
    end else if (model_fill == 0) begin
      res.status = STAT_UNDERFLOW;
    end else begin
      model_fill--;
      model_heap[0] = model_heap[model_fill];
      pos = 0;
      moved = 1'b1;
      while (moved) begin
        best = pos;
        kid = 2 * pos + 1;
        if (kid < model_fill && ranks_higher(model_heap[kid], model_heap[best])) best = kid;
        kid = 2 * pos + 2;
        if (kid < model_fill && ranks_higher(model_heap[kid], model_heap[best])) best = kid;
        moved = (best != pos);
        if (moved) begin
          swap_entries(best, pos);
          pos = best;
        end
      end
    end
    res.top_valid = (model_fill > 0);
    res.top_value = (model_fill > 0) ? model_heap[0] : '0;
    res.entry_count = CNT_W'(model_fill);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatches++;
    if (mismatches <= SHOWN_MAX)
      $display("%0t result %0d: %s got %0h, expected %0h", $time, results_seen, what,
               got, want);
  endtask

  task automatic check_result(input rsp_t got, input rsp_t want);
    if (got.top_value !== want.top_value)
      report_mismatch("top_value", got.top_value, want.top_value);
    if (got.top_valid !== want.top_valid)
      report_mismatch("top_valid", got.top_valid, want.top_valid);
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", got.entry_count, want.entry_count);
    if (got.status !== want.status)
      report_mismatch("status", got.status, want.status);
  endtask

  // newest expected result at the front, oldest taken from the back
  always @(posedge clk) begin
    if (rst) begin
      model_fill = 0;
      model_max_first = 1'b0;
      results_due.delete();
      items_taken <= 0;
      results_seen <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen <= results_seen + 1;
        if (results_due.size() == 0) report_mismatch("unexpected item", rsp.top_value, '0);
        else check_result(rsp, results_due.pop_back());
      end
      if (req_valid && !req_stall) begin
        items_taken <= items_taken + 1;
        results_due.push_front(apply_heap_op(req));
      end
      if (cfg_we) model_max_first = cfg_data;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import bhpq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int TAIL_CYCLES = 30;

  localparam logic signed [DATA_W-1:0] V_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] V_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int errors;
  int outstanding;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  binary_heap_priority_queue u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  bhpq_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result-side back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_or_pop(input func_t op, input logic signed [DATA_W-1:0] v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{func: op, value: v};
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic wait_all_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_order(input logic max_first);
    wait_all_results();
    cfg_we <= 1'b1;
    cfg_data <= max_first;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mix of extremes, a narrow band for ties and the full range
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return V_MIN;
      1: return V_MAX;
      2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int push_pct;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_order(1'b0);

    // smallest on top: empty pop, ties, extremes
    push_or_pop(FUNC_POP, 32'sd5);
    push_or_pop(FUNC_PUSH, 32'sd5);
    push_or_pop(FUNC_PUSH, 32'sd5);
    push_or_pop(FUNC_PUSH, V_MIN);
    push_or_pop(FUNC_PUSH, V_MAX);
    push_or_pop(FUNC_PUSH, 32'sd0);
    push_or_pop(FUNC_PUSH, -32'sd1);
    push_or_pop(FUNC_PUSH, 32'sd5);
    push_or_pop(FUNC_POP, V_MAX);
    push_or_pop(FUNC_POP, V_MIN);
    push_or_pop(FUNC_POP, 32'sd0);

    // order flipped with entries held, then drained past empty
    set_order(1'b1);
    push_or_pop(FUNC_PUSH, 32'sd3);
    push_or_pop(FUNC_PUSH, V_MAX);
    repeat (7) push_or_pop(FUNC_POP, -32'sd1);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph >= PHASES - 2) begin
        gaps_on = 1'b0;
        stalls_on <= 1'b0;
      end else begin
        gaps_on = ($urandom_range(0, 2) != 0);
        stalls_on <= ($urandom_range(0, 2) != 0);
      end
      set_order(ph < 2 ? ph[0] : 1'($urandom_range(0, 1)));
      case (ph % 4)
        0: push_pct = 85;
        1: push_pct = 25;
        2: push_pct = 50;
        default: push_pct = 70;
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) == 0) wait_all_results();
        push_or_pop(($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP, pick_value());
      end
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
